FILE: design/ldrf_pkg.sv
// Shared types, constants and helpers for the LCD dirty-region flush engine.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ldrf_pkg;

  // Display geometry.
  localparam int COLUMNS    = 84;
  localparam int BANKS      = 6;
  localparam int ROWS       = BANKS * 8;
  localparam int STORE_SIZE = COLUMNS * BANKS;
  localparam int MOVE_SIZE  = STORE_SIZE - COLUMNS;
  localparam int ADDR_W     = $clog2(STORE_SIZE);

  // Controller command prefixes.
  localparam logic [7:0] CMD_Y = 8'h40;
  localparam logic [7:0] CMD_X = 8'h80;

  // Action codes of an input transaction.
  localparam logic [2:0] ACT_STORE  = 3'd0;
  localparam logic [2:0] ACT_MARK   = 3'd1;
  localparam logic [2:0] ACT_CLEAR  = 3'd2;
  localparam logic [2:0] ACT_SCROLL = 3'd3;
  localparam logic [2:0] ACT_FLUSH  = 3'd4;
  localparam logic [2:0] ACT_TICK   = 3'd5;

  // Flush phases within one bank.
  localparam logic [1:0] PH_Y    = 2'd0;
  localparam logic [1:0] PH_X    = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] bank;
    logic [6:0] column;
    logic [7:0] value;
    logic [6:0] x_low;
    logic [5:0] y_low;
    logic [6:0] x_high;
    logic [5:0] y_high;
  } ldrf_in_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] byte_out;
    logic       last;
  } ldrf_out_t;

  // Dirty bounding box.
  typedef struct packed {
    logic [6:0] x_min;
    logic [6:0] x_max;
    logic [5:0] y_min;
    logic [5:0] y_max;
  } ldrf_box_t;

  // Update requests to the box tracker.
  typedef struct packed {
    logic grow;   // take in the rectangle of the current transaction
    logic fill;   // mark the whole screen dirty
    logic clr;    // back to the empty box
  } ldrf_box_ctl_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_TICK,
    ST_SCROLL,
    ST_ZERO
  } ldrf_state_t;

  // First store address of a bank.
  function automatic logic [ADDR_W-1:0] bank_base(input logic [2:0] b);
    return ADDR_W'(b) * ADDR_W'(COLUMNS);
  endfunction

endpackage

`default_nettype wire

FILE: design/lcd_dirty_region_flush.sv
// Top level of the LCD dirty-region flush engine: control sequencer, flush
// walker and output register. Depends on ldrf_pkg, ldrf_frame_mem, ldrf_box.
`default_nettype none

// The block keeps an 84 x 6 byte monochrome frame store and a dirty box.
// Input transactions (in_valid / in_stall) carry one action: store a byte,
// mark a rectangle dirty, clear, scroll up one bank, start a flush, or tick.
// Each tick during a flush yields one output transaction (out_valid /
// out_stall): a Y-address command, an X-address command, or a data byte,
// with last set on the final byte of the flush.
// Store, mark, start flush and idle ticks leave in_stall low. A flush tick
// first reads the store through its registered read port and then loads
// the byte into the output register; while the output register is still
// full and stalled, the tick waits there.
// Clear sweeps the whole store. Scroll copies 420 entries through a
// read-to-write pipeline and then zeroes the last bank. In_stall is high
// during these sweeps.
// After reset the block runs the same clearing pass before it takes its
// first transaction. A stalled receiver only holds the output register;
// the block still takes the next transaction behind it.
// While a flush is under way every action other than tick is accepted and
// ignored.

module lcd_dirty_region_flush
  import ldrf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ldrf_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output ldrf_out_t      out_data
);

  ldrf_state_t   state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;

  logic          flushing_r, flushing_nxt;
  logic [2:0]    flush_bank_r, flush_bank_nxt;
  logic [6:0]    flush_col_r, flush_col_nxt;
  logic [1:0]    flush_phase_r, flush_phase_nxt;
  logic [ADDR_W-1:0] flush_addr_r, flush_addr_nxt;

  logic          out_valid_r, out_valid_nxt;
  ldrf_out_t     out_data_r, out_data_nxt;

  logic          in_accept;
  logic          out_free;
  logic          box_empty;
  logic          flush_done;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;

  ldrf_box_ctl_t box_ctl;
  ldrf_box_t     box;

  ldrf_frame_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ldrf_box u_box (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (box_ctl),
    .rect  (in_data),
    .box   (box)
  );

  // Transactions are taken only between sweeps and flush ticks.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign box_empty = (box.x_min > box.x_max) || (box.y_min > box.y_max);
  // The last data byte of the last bank that the box touches.
  assign flush_done = (flush_col_r >= box.x_max) &&
                      (flush_bank_r >= 3'(box.y_max >> 3));

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    flushing_nxt    = flushing_r;
    flush_bank_nxt  = flush_bank_r;
    flush_col_nxt   = flush_col_r;
    flush_phase_nxt = flush_phase_r;
    flush_addr_nxt  = flush_addr_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    mem_we          = 1'b0;
    mem_waddr       = cnt_r;
    mem_wdata       = 8'h00;
    mem_re          = 1'b0;
    mem_raddr       = flush_addr_r;
    box_ctl         = '0;

    unique case (state_r)
      ST_CLR: begin
        // Zero sweep, used both after reset and for the clear action.
        mem_we = 1'b1;
        if (cnt_r == ADDR_W'(STORE_SIZE - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          if (flushing_r) begin
            if (in_data.action == ACT_TICK) begin
              state_nxt = ST_TICK;
              mem_re    = (flush_phase_r == PH_DATA);
            end
          end else begin
            unique case (in_data.action)
              ACT_STORE: begin
                if ((4'(in_data.bank) < 4'(BANKS)) &&
                    (8'(in_data.column) < 8'(COLUMNS))) begin
                  mem_we    = 1'b1;
                  mem_waddr = bank_base(in_data.bank) + ADDR_W'(in_data.column);
                  mem_wdata = in_data.value;
                end
              end
              ACT_MARK: begin
                box_ctl.grow = 1'b1;
              end
              ACT_CLEAR: begin
                box_ctl.fill = 1'b1;
                state_nxt    = ST_CLR;
                cnt_nxt      = '0;
              end
              ACT_SCROLL: begin
                box_ctl.fill = 1'b1;
                state_nxt    = ST_SCROLL;
                cnt_nxt      = '0;
              end
              ACT_FLUSH: begin
                if (box_empty) begin
                  box_ctl.clr = 1'b1;
                end else begin
                  flushing_nxt    = 1'b1;
                  flush_bank_nxt  = 3'(box.y_min >> 3);
                  flush_col_nxt   = box.x_min;
                  flush_phase_nxt = PH_Y;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      ST_TICK: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          case (flush_phase_r)
            PH_X: begin
              out_data_nxt.is_data  = 1'b0;
              out_data_nxt.byte_out = CMD_X | 8'(box.x_min);
              out_data_nxt.last     = 1'b0;
              flush_col_nxt         = box.x_min;
              flush_addr_nxt        = bank_base(flush_bank_r) + ADDR_W'(box.x_min);
              flush_phase_nxt       = PH_DATA;
            end
            PH_DATA: begin
              out_data_nxt.is_data  = 1'b1;
              out_data_nxt.byte_out = mem_rdata;
              out_data_nxt.last     = 1'b0;
              if (flush_col_r >= box.x_max) begin
                if (flush_done) begin
                  out_data_nxt.last = 1'b1;
                  flushing_nxt      = 1'b0;
                  flush_bank_nxt    = '0;
                  flush_col_nxt     = '0;
                  flush_phase_nxt   = PH_Y;
                  box_ctl.clr       = 1'b1;
                end else begin
                  flush_bank_nxt  = flush_bank_r + 1'b1;
                  flush_phase_nxt = PH_Y;
                end
              end else begin
                flush_col_nxt  = flush_col_r + 1'b1;
                flush_addr_nxt = flush_addr_r + 1'b1;
              end
            end
            default: begin
              // Y-address command; the unused phase code behaves the same.
              out_data_nxt.is_data  = 1'b0;
              out_data_nxt.byte_out = CMD_Y | 8'(flush_bank_r);
              out_data_nxt.last     = 1'b0;
              flush_phase_nxt       = PH_X;
            end
          endcase
        end
      end

      ST_SCROLL: begin
        // Read one bank ahead and write the previous read in the next cycle.
        // Writes trail reads, so no source entry is overwritten early.
        if (cnt_r < ADDR_W'(MOVE_SIZE)) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_r + ADDR_W'(COLUMNS);
        end
        if (cnt_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r - 1'b1;
          mem_wdata = mem_rdata;
        end
        if (cnt_r == ADDR_W'(MOVE_SIZE)) begin
          state_nxt = ST_ZERO;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_ZERO: begin
        // Blank the bottom bank after a scroll.
        mem_we = 1'b1;
        if (cnt_r == ADDR_W'(STORE_SIZE - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLR;
      cnt_r         <= '0;
      flushing_r    <= 1'b0;
      flush_bank_r  <= '0;
      flush_col_r   <= '0;
      flush_phase_r <= PH_Y;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      flushing_r    <= flushing_nxt;
      flush_bank_r  <= flush_bank_nxt;
      flush_col_r   <= flush_col_nxt;
      flush_phase_r <= flush_phase_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flush_addr_r <= flush_addr_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A flush only runs over a non-empty box, and the box holds still meanwhile.
  a_flush_box: assert property (@(posedge clk) disable iff (!rst_n)
    flushing_r |-> (box.x_min <= box.x_max) && (box.y_min <= box.y_max))
    else $error("flush running over an empty dirty box");

  // The flush walker never leaves the bank range.
  a_flush_bank: assert property (@(posedge clk) disable iff (!rst_n)
    flushing_r |-> (4'(flush_bank_r) < 4'(BANKS)))
    else $error("flush bank out of range");

  // The final byte of a flush ends the flush on the same edge.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && out_data_r.last) |-> !flushing_r)
    else $error("flush still running after its last byte");
`endif

endmodule

`default_nettype wire

FILE: design/ldrf_frame_mem.sv
// Frame store: one write port and one read port with a registered read.
// Depends on ldrf_pkg for the depth and address width.
`default_nettype none

module ldrf_frame_mem
  import ldrf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [STORE_SIZE];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: design/ldrf_box.sv
// Dirty bounding box tracker: clamps and merges marked rectangles.
// Depends on ldrf_pkg for the geometry and the box types.
`default_nettype none

module ldrf_box
  import ldrf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ldrf_box_ctl_t ctl,
  input  wire ldrf_in_t      rect,
  output ldrf_box_t          box
);

  ldrf_box_t box_r;
  ldrf_box_t box_nxt;
  logic [6:0] xl;
  logic [6:0] xh;
  logic [5:0] yl;
  logic [5:0] yh;

  always_comb begin
    xl = (rect.x_low  > 7'(COLUMNS - 1)) ? 7'(COLUMNS - 1) : rect.x_low;
    xh = (rect.x_high > 7'(COLUMNS - 1)) ? 7'(COLUMNS - 1) : rect.x_high;
    yl = (rect.y_low  > 6'(ROWS - 1))    ? 6'(ROWS - 1)    : rect.y_low;
    yh = (rect.y_high > 6'(ROWS - 1))    ? 6'(ROWS - 1)    : rect.y_high;
    box_nxt = box_r;
    if (ctl.clr) begin
      box_nxt.x_min = 7'(COLUMNS - 1);
      box_nxt.x_max = '0;
      box_nxt.y_min = 6'(ROWS - 1);
      box_nxt.y_max = '0;
    end else if (ctl.fill) begin
      box_nxt.x_min = '0;
      box_nxt.x_max = 7'(COLUMNS - 1);
      box_nxt.y_min = '0;
      box_nxt.y_max = 6'(ROWS - 1);
    end else if (ctl.grow) begin
      if (xl < box_r.x_min) box_nxt.x_min = xl;
      if (xh > box_r.x_max) box_nxt.x_max = xh;
      if (yl < box_r.y_min) box_nxt.y_min = yl;
      if (yh > box_r.y_max) box_nxt.y_max = yh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r.x_min <= 7'(COLUMNS - 1);
      box_r.x_max <= '0;
      box_r.y_min <= 6'(ROWS - 1);
      box_r.y_max <= '0;
    end else begin
      box_r <= box_nxt;
    end
  end

  assign box = box_r;

endmodule

`default_nettype wire
